// ----- rtl/kcst_pkg.sv -----
// Package with the word types, sizing constants and name helper of the tally.
`timescale 1ns / 1ps
package kcst_pkg;

  localparam int unsigned MaxEntriesDef = 256;
  localparam int unsigned NameBytesDef = 128;

  typedef struct packed {
    logic        mode;
    logic [63:0] name_chunk;
    logic        chunk_last;
    logic [15:0] sight_count;
    logic [7:0]  entry_index;
    logic [3:0]  chunk_index;
  } kcst_in_t;

  typedef struct packed {
    logic [7:0]  entry;
    logic        is_new;
    logic        table_full;
    logic        entry_valid;
    logic [63:0] name_chunk_out;
    logic [15:0] pods;
    logic [31:0] whales;
    logic [8:0]  species_count;
  } kcst_out_t;

  localparam logic ModeSighting = 1'b0;
  localparam logic ModeRead = 1'b1;

  // Clears the bytes after the first zero byte (all bytes once ended is set); bit 64 tells whether the name has ended.
  function automatic logic [64:0] kcst_normalize(input logic [63:0] w, input logic ended);
    logic [63:0] r;
    logic        e;
    r = w;
    e = ended;
    for (int b = 0; b < 8; b++) begin
      if (e) begin
        r[b*8 +: 8] = 8'h00;
      end else if (w[b*8 +: 8] == 8'h00) begin
        e = 1'b1;
      end
    end
    return {e, r};
  endfunction

endpackage

// ----- rtl/kcst_if.sv -----
// Valid/ready channel interfaces for sighting words and result words.
`timescale 1ns / 1ps
interface kcst_in_if;
  logic               valid;
  logic               ready;
  kcst_pkg::kcst_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface kcst_out_if;
  logic                valid;
  logic                ready;
  kcst_pkg::kcst_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/kcst_cell.sv -----
// One name chunk cell: holds a buffered chunk and its slice of the key store.
`timescale 1ns / 1ps
module kcst_cell #(
  parameter int unsigned MAX_ENTRIES = kcst_pkg::MaxEntriesDef,
  parameter int unsigned IDX = 0,
  parameter int unsigned PW = 1,
  parameter type tok_t = logic,
  parameter type ctl_t = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic [63:0] key_mem [MAX_ENTRIES];
  logic [63:0] rd_r;
  logic [63:0] buf_r;
  tok_t        tok_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      key_mem[ctl.addr] <= buf_r;
    end
    rd_r <= key_mem[tok_in.entry];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      buf_r <= '0;
    end else begin
      tok_r <= tok_in;
      if (ctl.clr) begin
        buf_r <= '0;
      end else if (ctl.ld && ctl.pos == PW'(IDX)) begin
        buf_r <= ctl.data;
      end
    end
  end

  always_comb begin
    tok_out = tok_r;
    tok_out.match = tok_r.match & (rd_r == buf_r);
    if (tok_r.rd && tok_r.sel == PW'(IDX)) begin
      tok_out.data = rd_r;
    end
  end

endmodule

// ----- rtl/keyed_count_sum_tally.sv -----
// Group-by tally: a name chunk word that is not the last gives its result in the
// next cycle. A last chunk word sends every stored entry through the row of chunk
// cells, one stored entry entering the row per cycle, then passes ST_LOOK and
// ST_UPD; a read word sends one token through the row and then the same states.
// One word is worked on at a time; the result register frees the input side.
// Synchronous active-low reset empties the table and the name buffer; key and
// count memories are not cleared.
`timescale 1ns / 1ps
module keyed_count_sum_tally #(
  parameter int unsigned MAX_ENTRIES = kcst_pkg::MaxEntriesDef,
  parameter int unsigned NAME_BYTES = kcst_pkg::NameBytesDef
) (
  input logic        clk,
  input logic        rst_n,
  kcst_in_if.sink    in_ch,
  kcst_out_if.source out_ch
);

  localparam int unsigned CHUNKS = NAME_BYTES / 8;
  localparam int unsigned PW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned QW = $clog2(CHUNKS + 1);
  localparam int unsigned EW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic          vld;
    logic          rd;
    logic [EW-1:0] entry;
    logic [PW-1:0] sel;
    logic          match;
    logic [63:0]   data;
  } tok_t;

  typedef struct packed {
    logic          ld;
    logic          clr;
    logic          wr;
    logic [PW-1:0] pos;
    logic [EW-1:0] addr;
    logic [63:0]   data;
  } ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_UPD  = 4'b1000
  } st_t;

  st_t                 st_r, st_nxt;
  logic [QW-1:0]       pos_r, pos_nxt;
  logic                ended_r, ended_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic [CW-1:0]       ret_r, ret_nxt;
  logic [CW-1:0]       ntok_r, ntok_nxt;
  logic                mode_r, mode_nxt;
  logic [15:0]         amt_r, amt_nxt;
  logic [7:0]          eidx_r, eidx_nxt;
  logic [3:0]          cidx_r, cidx_nxt;
  logic                found_r, found_nxt;
  logic [EW-1:0]       hit_r, hit_nxt;
  logic [63:0]         data_r, data_nxt;
  kcst_pkg::kcst_out_t out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;

  logic [15:0]   pods_mem [MAX_ENTRIES];
  logic [31:0]   whales_mem [MAX_ENTRIES];
  logic [15:0]   pods_rd_r;
  logic [31:0]   whales_rd_r;
  logic          pw_we;
  logic [EW-1:0] pw_wa, pw_ra;
  logic [15:0]   pods_wd;
  logic [31:0]   whales_wd;

  ctl_t          ctl;
  tok_t          tok [CHUNKS+1];
  logic          out_free;
  logic          acc;
  logic [64:0]   norm;
  logic [32:0]   wsum;
  logic          rd_ok;

  assign out_free = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;
  assign norm = kcst_pkg::kcst_normalize(in_ch.data.name_chunk, ended_r);
  assign wsum = {1'b0, whales_rd_r} + {17'b0, amt_r};
  assign rd_ok = ({{CW{1'b0}}, eidx_r} < {8'b0, cnt_r})
              && ({{CW{1'b0}}, eidx_r} < (CW + 8)'(MAX_ENTRIES));

  always_comb begin
    tok[0].vld = (st_r == ST_SCAN) && (iss_r < ntok_r);
    tok[0].rd = mode_r;
    tok[0].entry = mode_r ? EW'(eidx_r) : iss_r[EW-1:0];
    tok[0].sel = PW'(cidx_r);
    tok[0].match = 1'b1;
    tok[0].data = '0;
  end

  for (genvar c = 0; c < CHUNKS; c++) begin : g_cell
    kcst_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .IDX(c),
      .PW(PW),
      .tok_t(tok_t),
      .ctl_t(ctl_t)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .ctl(ctl),
      .tok_in(tok[c]),
      .tok_out(tok[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pods_mem[pw_wa] <= pods_wd;
      whales_mem[pw_wa] <= whales_wd;
    end
    pods_rd_r <= pods_mem[pw_ra];
    whales_rd_r <= whales_mem[pw_ra];
  end

  always_comb begin
    st_nxt = st_r;
    pos_nxt = pos_r;
    ended_nxt = ended_r;
    cnt_nxt = cnt_r;
    iss_nxt = iss_r;
    ret_nxt = ret_r;
    ntok_nxt = ntok_r;
    mode_nxt = mode_r;
    amt_nxt = amt_r;
    eidx_nxt = eidx_r;
    cidx_nxt = cidx_r;
    found_nxt = found_r;
    hit_nxt = hit_r;
    data_nxt = data_r;
    out_nxt = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    ctl = '0;
    ctl.pos = pos_r[PW-1:0];
    ctl.data = norm[63:0];
    ctl.addr = cnt_r[EW-1:0];
    pw_we = 1'b0;
    pw_wa = hit_r;
    pw_ra = mode_r ? EW'(eidx_r) : hit_r;
    pods_wd = '0;
    whales_wd = '0;

    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          mode_nxt = in_ch.data.mode;
          amt_nxt = in_ch.data.sight_count;
          eidx_nxt = in_ch.data.entry_index;
          cidx_nxt = in_ch.data.chunk_index;
          iss_nxt = '0;
          ret_nxt = '0;
          found_nxt = 1'b0;
          data_nxt = '0;
          if (in_ch.data.mode == kcst_pkg::ModeSighting) begin
            if (pos_r < QW'(CHUNKS)) begin
              ctl.ld = 1'b1;
              pos_nxt = pos_r + QW'(1);
              ended_nxt = norm[64];
            end
            if (in_ch.data.chunk_last) begin
              ntok_nxt = cnt_r;
              st_nxt = ST_SCAN;
            end else begin
              out_nxt = '0;
              out_nxt.species_count = 9'(cnt_r);
              out_vld_nxt = 1'b1;
            end
          end else begin
            ntok_nxt = CW'(1);
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tok[0].vld) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (tok[CHUNKS].vld) begin
          ret_nxt = ret_r + CW'(1);
          if (tok[CHUNKS].rd) begin
            data_nxt = tok[CHUNKS].data;
          end else if (tok[CHUNKS].match && !found_r) begin
            found_nxt = 1'b1;
            hit_nxt = tok[CHUNKS].entry;
          end
        end
        if (ret_r == ntok_r && iss_r == ntok_r) begin
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_nxt = '0;
          out_vld_nxt = 1'b1;
          st_nxt = ST_IDLE;
          if (mode_r == kcst_pkg::ModeRead) begin
            out_nxt.entry = eidx_r;
            if (rd_ok) begin
              out_nxt.entry_valid = 1'b1;
              out_nxt.pods = pods_rd_r;
              out_nxt.whales = whales_rd_r;
              if ({4'b0, cidx_r} < 8'(CHUNKS)) begin
                out_nxt.name_chunk_out = data_r;
              end
            end
          end else begin
            ctl.clr = 1'b1;
            pos_nxt = '0;
            ended_nxt = 1'b0;
            if (found_r) begin
              pw_we = 1'b1;
              pods_wd = (pods_rd_r == 16'hFFFF) ? pods_rd_r : pods_rd_r + 16'd1;
              whales_wd = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
              out_nxt.entry = 8'(hit_r);
              out_nxt.entry_valid = 1'b1;
              out_nxt.pods = pods_wd;
              out_nxt.whales = whales_wd;
            end else if (cnt_r < CW'(MAX_ENTRIES)) begin
              pw_we = 1'b1;
              pw_wa = cnt_r[EW-1:0];
              pods_wd = 16'd1;
              whales_wd = {16'b0, amt_r};
              ctl.wr = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              out_nxt.entry = 8'(cnt_r);
              out_nxt.is_new = 1'b1;
              out_nxt.entry_valid = 1'b1;
              out_nxt.pods = pods_wd;
              out_nxt.whales = whales_wd;
            end else begin
              out_nxt.table_full = 1'b1;
            end
          end
          out_nxt.species_count = 9'(cnt_nxt);
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pos_r <= '0;
      ended_r <= 1'b0;
      cnt_r <= '0;
      iss_r <= '0;
      ret_r <= '0;
      ntok_r <= '0;
      found_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      ended_r <= ended_nxt;
      cnt_r <= cnt_nxt;
      iss_r <= iss_nxt;
      ret_r <= ret_nxt;
      ntok_r <= ntok_nxt;
      found_r <= found_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    amt_r <= amt_nxt;
    eidx_r <= eidx_nxt;
    cidx_r <= cidx_nxt;
    hit_r <= hit_nxt;
    data_r <= data_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- rtl/kcst_chk.sv -----
// Port checker for the tally, bound to the top level.
`timescale 1ns / 1ps
module kcst_chk #(
  parameter int unsigned MAX_ENTRIES = kcst_pkg::MaxEntriesDef
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input kcst_pkg::kcst_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Result word changed while stalled.");

  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_new |->
      out_data.entry_valid && !out_data.table_full && out_data.pods == 16'd1)
    else $error("Fresh entry reported with wrong fields.");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |->
      out_data.species_count == 9'(MAX_ENTRIES) && !out_data.entry_valid)
    else $error("Table full reported before all entries are taken.");

endmodule

bind keyed_count_sum_tally kcst_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_kcst_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
